// ----- design/assert_macros.svh -----
// assertion macros used by the pid controller top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/pcm_pkg.sv -----
// types, codes and saturation helpers for the pid controller
package pcm_pkg;

	localparam int unsigned DIV_QBITS = 31;

	localparam logic [2:0] MODE_AUTO    = 3'd0;
	localparam logic [2:0] MODE_CASCADE = 3'd1;
	localparam logic [2:0] MODE_HALT    = 3'd2;
	localparam logic [2:0] MODE_MANUAL  = 3'd3;
	localparam logic [2:0] MODE_RESET   = 3'd4;

	localparam logic [2:0] STRUCT_P   = 3'd0;
	localparam logic [2:0] STRUCT_I   = 3'd1;
	localparam logic [2:0] STRUCT_PI  = 3'd2;
	localparam logic [2:0] STRUCT_PD  = 3'd3;
	localparam logic [2:0] STRUCT_PID = 3'd4;

	localparam logic [2:0] REG_STRUCTURE = 3'd0;
	localparam logic [2:0] REG_GAIN      = 3'd1;
	localparam logic [2:0] REG_TI        = 3'd2;
	localparam logic [2:0] REG_TD        = 3'd3;
	localparam logic [2:0] REG_TF        = 3'd4;
	localparam logic [2:0] REG_OUT_MAX   = 3'd5;
	localparam logic [2:0] REG_OUT_MIN   = 3'd6;
	localparam logic [2:0] REG_FF        = 3'd7;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [32:0] a;
		logic [30:0]        b;
	} mul_req_t;

	typedef struct packed {
		logic               neg;
		logic [63:0]        prod;
		logic signed [31:0] res;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic        neg;
		logic [62:0] mag;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_rsp_t;

	typedef enum logic [18:0] {
		S_IDLE   = 19'd1 << 0,
		S_ERR    = 19'd1 << 1,
		S_DIFF   = 19'd1 << 2,
		S_PMUL   = 19'd1 << 3,
		S_PWR    = 19'd1 << 4,
		S_TWR    = 19'd1 << 5,
		S_TMUL   = 19'd1 << 6,
		S_IDIV   = 19'd1 << 7,
		S_IWAIT  = 19'd1 << 8,
		S_DMA    = 19'd1 << 9,
		S_DMB    = 19'd1 << 10,
		S_DMC    = 19'd1 << 11,
		S_DMD    = 19'd1 << 12,
		S_DSUM   = 19'd1 << 13,
		S_DDIV   = 19'd1 << 14,
		S_DWAIT  = 19'd1 << 15,
		S_OSUM   = 19'd1 << 16,
		S_OCLAMP = 19'd1 << 17,
		S_OUT    = 19'd1 << 18
	} state_t;

	// signed value from a magnitude and a sign, saturated to 32 bits
	function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
		if (neg) begin
			if (m >= 64'h0000_0000_8000_0000) return S32_MIN;
			return 32'(-m[31:0]);
		end
		if (m >= 64'h0000_0000_7FFF_FFFF) return S32_MAX;
		return m[31:0];
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v > 34'(S32_MAX)) return S32_MAX;
		if (v < 34'(S32_MIN)) return S32_MIN;
		return v[31:0];
	endfunction

endpackage

// ----- design/pcm_mul.sv -----
// shared registered multiplier with shift and saturation
module pcm_mul import pcm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [32:0] mag;
	logic [63:0] prod_c;
	logic [63:0] prod_q;
	logic        neg_q;
	logic [63:0] shr;

	assign mag    = req.a[32] ? 33'(-req.a) : 33'(req.a);
	assign prod_c = mag * req.b;

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		neg_q  <= req.a[32];
	end

	assign shr      = prod_q >> FRAC_BITS;
	assign rsp.neg  = neg_q;
	assign rsp.prod = prod_q;
	assign rsp.res  = sat_mag(neg_q, shr);

endmodule

// ----- design/pcm_div.sv -----
// shared restoring divider, one quotient bit per cycle, saturating
module pcm_div import pcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [4:0]           cnt_q;
	logic [62:0]          rem_q;
	logic [62:0]          dsh_q;
	logic [DIV_QBITS-1:0] quo_q;
	logic                 neg_q;
	logic                 sat_q;
	logic                 sat_c;
	logic                 ge;

	assign sat_c = req.mag >= {req.den, {DIV_QBITS{1'b0}}};
	assign ge    = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= !sat_c;
				done_q <= sat_c;
				cnt_q  <= 5'(DIV_QBITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.mag;
			dsh_q <= 63'(req.den) << (DIV_QBITS - 1);
			quo_q <= '0;
			neg_q <= req.neg;
			sat_q <= sat_c;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[DIV_QBITS-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sat_q ? (neg_q ? S32_MIN : S32_MAX) : sat_mag(neg_q, 64'(quo_q));

endmodule

// ----- design/pid_controller_modes_top.sv -----
// pid controller with filtered derivative and operating modes, top level
//
// input channel: setpoint, process_value and mode, taken when in_valid is high
// and in_stall is low; in_stall is high while a sample is being worked on.
// output channel: drive_output and clamped, held in an output register until
// out_valid is seen with out_stall low; a new request is taken while a result
// still waits there, and the sequencer holds its last step until it is free.
// a sample runs through the sequencer steps and two passes of the shared
// bit-serial divider (integral step and derivative filter) before out_valid;
// a pass whose quotient saturates skips its bit-serial steps. the next request
// can be taken in the cycle after the result is loaded. every product goes
// through one shared registered multiplier. reset mode skips to the output step.
// config writes on cfg_write are taken at once; the user must make them only
// while no sample is in flight, as the block itself does not enforce it.
// arst_n clears the controller state, the config registers to their defaults
// and out_valid, but not drive_output or clamped; the block is ready right after reset.
`include "assert_macros.svh"
module pid_controller_modes_top import pcm_pkg::*; #(
	parameter int SAMPLE_PERIOD = 65536,
	parameter int FRAC_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] setpoint,
	input  logic signed [31:0] process_value,
	input  logic [2:0]         mode,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] drive_output,
	output logic               clamped,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam logic [30:0] SP = SAMPLE_PERIOD[30:0];

	state_t state_q;

	logic [3:0]         structure_q;
	logic [30:0]        gain_q;
	logic [30:0]        ti_q;
	logic [30:0]        td_q;
	logic [30:0]        tf_q;
	logic signed [31:0] out_max_q;
	logic signed [31:0] out_min_q;
	logic signed [31:0] ff_q;

	logic signed [31:0] integ_q;
	logic signed [31:0] dterm_q;
	logic signed [31:0] prop_q;
	logic signed [31:0] prev_err_q;
	logic signed [31:0] prev_pv_q;
	logic signed [31:0] last_out_q;

	logic signed [31:0] sp_q;
	logic signed [31:0] pv_q;
	logic signed [31:0] err_q;
	logic signed [31:0] diff_q;
	logic signed [32:0] sum_q;
	logic signed [31:0] t_q;
	logic signed [31:0] a_q;
	logic signed [31:0] b_q;
	logic signed [33:0] s_q;
	logic signed [31:0] y_q;
	logic               lim_q;
	logic               do_p_q;
	logic               do_i_q;
	logic               do_back_q;
	logic               do_d_q;

	logic               out_valid_q;
	logic signed [31:0] drive_q;
	logic               clamped_q;

	logic               in_acc;
	logic               out_free;
	logic               autom;
	logic               casc;
	logic               manhalt;
	logic               f_p;
	logic               f_i;
	logic               f_back;
	logic               f_d;
	logic [30:0]        ti_eff;
	logic [33:0]        s_mag;
	logic               div_wait;
	logic               at_limit;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	pcm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk (clk),
		.req (mul_req),
		.rsp (mul_rsp)
	);

	pcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// per-structure mode rules
	always_comb begin
		autom   = (mode == MODE_AUTO);
		casc    = (mode == MODE_CASCADE);
		manhalt = (mode inside {MODE_HALT, MODE_MANUAL});
		f_p     = 1'b0;
		f_i     = 1'b0;
		f_back  = 1'b0;
		f_d     = 1'b0;
		case (structure_q[2:0])
			STRUCT_P: begin
				f_p = 1'b1;
			end
			STRUCT_PI: begin
				f_p    = autom || manhalt;
				f_i    = autom;
				f_back = manhalt;
			end
			STRUCT_PD: begin
				f_p = autom || casc;
				f_d = autom || casc;
			end
			STRUCT_PID: begin
				f_p    = autom || casc || manhalt;
				f_i    = autom || casc;
				f_back = manhalt;
				f_d    = autom || casc;
			end
			default: begin
				f_p = 1'b0;
			end
		endcase
	end

	assign ti_eff = (ti_q == 31'd0) ? 31'd1 : ti_q;
	assign s_mag  = s_q[33] ? 34'(-s_q) : 34'(s_q);

	// shared unit operand selection
	always_comb begin
		mul_req.a = 33'(err_q);
		mul_req.b = gain_q;
		case (state_q)
			S_PWR: begin
				mul_req.a = sum_q;
			end
			S_TMUL: begin
				mul_req.a = 33'(t_q);
				mul_req.b = SP;
			end
			S_DMA: begin
				mul_req.a = 33'(dterm_q);
				mul_req.b = tf_q;
			end
			S_DMB: begin
				mul_req.a = 33'(diff_q);
			end
			S_DMD: begin
				mul_req.a = 33'(b_q);
				mul_req.b = td_q;
			end
			default: begin
				mul_req.a = 33'(err_q);
			end
		endcase
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.neg   = mul_rsp.neg;
		div_req.mag   = mul_rsp.prod[62:0];
		div_req.den   = {ti_eff, 1'b0};
		case (state_q)
			S_IDIV: begin
				div_req.start = 1'b1;
			end
			S_DDIV: begin
				div_req.start = 1'b1;
				div_req.neg   = s_q[33];
				div_req.mag   = 63'(s_mag) << FRAC_BITS;
				div_req.den   = 32'(SP) + 32'(tf_q);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			structure_q <= {1'b0, STRUCT_PID};
			gain_q      <= 31'd65536;
			ti_q        <= 31'd65536;
			td_q        <= '0;
			tf_q        <= '0;
			out_max_q   <= 32'sd983040;
			out_min_q   <= -32'sd983040;
			ff_q        <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STRUCTURE: structure_q <= cfg_data[3:0];
				REG_GAIN:      gain_q      <= cfg_data[30:0];
				REG_TI:        ti_q        <= cfg_data[30:0];
				REG_TD:        td_q        <= cfg_data[30:0];
				REG_TF:        tf_q        <= cfg_data[30:0];
				REG_OUT_MAX:   out_max_q   <= cfg_data;
				REG_OUT_MIN:   out_min_q   <= cfg_data;
				REG_FF:        ff_q        <= cfg_data;
				default:       ff_q        <= ff_q;
			endcase
		end
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			integ_q     <= '0;
			dterm_q     <= '0;
			prop_q      <= '0;
			prev_err_q  <= '0;
			prev_pv_q   <= '0;
			last_out_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (mode >= MODE_RESET) begin
							integ_q    <= '0;
							dterm_q    <= '0;
							prop_q     <= '0;
							prev_err_q <= '0;
							prev_pv_q  <= '0;
							last_out_q <= '0;
							state_q    <= S_OUT;
						end else begin
							state_q <= S_ERR;
						end
					end
				end
				S_ERR:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_PMUL;
				S_PMUL: state_q <= S_PWR;
				S_PWR: begin
					if (do_p_q) prop_q <= mul_rsp.res;
					state_q <= S_TWR;
				end
				S_TWR:  state_q <= S_TMUL;
				S_TMUL: state_q <= S_IDIV;
				S_IDIV: state_q <= S_IWAIT;
				S_IWAIT: begin
					if (div_rsp.done) begin
						if (do_i_q) begin
							integ_q <= sat34(34'(integ_q) + 34'(div_rsp.quo));
						end else if (do_back_q) begin
							integ_q <= sat34(34'(last_out_q) - 34'(prop_q) - 34'(ff_q));
						end
						state_q <= S_DMA;
					end
				end
				S_DMA:  state_q <= S_DMB;
				S_DMB:  state_q <= S_DMC;
				S_DMC:  state_q <= S_DMD;
				S_DMD:  state_q <= S_DSUM;
				S_DSUM: state_q <= S_DDIV;
				S_DDIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_rsp.done) begin
						if (do_d_q) dterm_q <= div_rsp.quo;
						prev_err_q <= err_q;
						prev_pv_q  <= pv_q;
						state_q    <= S_OSUM;
					end
				end
				S_OSUM: state_q <= S_OCLAMP;
				S_OCLAMP: begin
					if (y_q < out_min_q) begin
						last_out_q <= out_min_q;
					end else if (y_q > out_max_q) begin
						last_out_q <= out_max_q;
					end else begin
						last_out_q <= y_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					sp_q      <= setpoint;
					pv_q      <= process_value;
					do_p_q    <= f_p;
					do_i_q    <= f_i;
					do_back_q <= f_back;
					do_d_q    <= f_d;
					y_q       <= '0;
					lim_q     <= 1'b0;
				end
			end
			S_ERR: begin
				err_q <= sat34(34'(sp_q) - 34'(pv_q));
			end
			S_DIFF: begin
				diff_q <= structure_q[3] ? sat34(34'(prev_pv_q) - 34'(pv_q))
				                         : sat34(34'(err_q) - 34'(prev_err_q));
				sum_q  <= 33'(err_q) + 33'(prev_err_q);
			end
			S_TWR: begin
				t_q <= mul_rsp.res;
			end
			S_DMB: begin
				a_q <= mul_rsp.res;
			end
			S_DMC: begin
				b_q <= mul_rsp.res;
			end
			S_DSUM: begin
				s_q <= 34'(a_q) + 34'(mul_rsp.res);
			end
			S_OSUM: begin
				y_q <= sat34(34'(prop_q) + 34'(integ_q) + 34'(dterm_q) + 34'(ff_q));
			end
			S_OCLAMP: begin
				if (y_q < out_min_q) begin
					y_q   <= out_min_q;
					lim_q <= 1'b1;
				end else if (y_q > out_max_q) begin
					y_q   <= out_max_q;
					lim_q <= 1'b1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					drive_q   <= y_q;
					clamped_q <= lim_q;
				end
			end
			default: begin
				lim_q <= lim_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign drive_output = drive_q;
	assign clamped      = clamped_q;

	assign div_wait = (state_q == S_IWAIT) || (state_q == S_DWAIT);
	assign at_limit = (drive_q == out_max_q) || (drive_q == out_min_q);

	`ASSERT_NEXT(a_busy_after_request, clk, arst_n, in_acc, in_stall, "request not held busy")
	`ASSERT_IMPLIES(a_div_done_in_wait, clk, arst_n, div_rsp.done, div_wait, "stray divider result")
	`ASSERT_IMPLIES(a_clamp_at_limit, clk, arst_n, out_valid && clamped, at_limit, "clamp off limits")

endmodule

// ----- bench/pid_drive_checker.sv -----
// checker for the pid controller: predicts each drive output and compares it with the block
module pid_drive_checker import pcm_pkg::*; #(
	parameter int SAMPLE_PERIOD = 65536,
	parameter int FRAC_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] setpoint,
	input  logic signed [31:0] process_value,
	input  logic [2:0]         mode,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] drive_output,
	input  logic               clamped,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fault_count,
	output int                 results_owed
);

	typedef struct packed {
		logic signed [31:0] drive;
		logic               clamped;
	} drive_t;

	drive_t drive_due[$];
	drive_t got, want;

	logic [3:0]  structure;
	logic [63:0] kp, ti, td, tf;
	longint      out_hi, out_lo, bias;
	longint      i_acc, d_acc, p_acc, e_prev, pv_prev, y_prev;

	function automatic longint clip32(input longint v);
		if (v > longint'(S32_MAX)) return longint'(S32_MAX);
		if (v < longint'(S32_MIN)) return longint'(S32_MIN);
		return v;
	endfunction

	function automatic longint signed_from_mag(input logic neg, input logic [63:0] m);
		if (neg) return (m >= 64'h8000_0000) ? longint'(S32_MIN) : -longint'(m);
		return (m >= 64'h7FFF_FFFF) ? longint'(S32_MAX) : longint'(m);
	endfunction

	// exact product, shifted down by magnitude, saturated
	function automatic longint scale_mul(input longint a, input logic [63:0] b);
		logic        neg;
		logic [63:0] m;
		neg = a < 0;
		m = neg ? 64'(-a) : 64'(a);
		return signed_from_mag(neg, (m * b) >> FRAC_BITS);
	endfunction

	function automatic longint div_trunc(input longint n, input logic [63:0] d);
		logic        neg;
		logic [63:0] m;
		neg = n < 0;
		m = neg ? 64'(-n) : 64'(n);
		return signed_from_mag(neg, m / d);
	endfunction

	task automatic predict_drive(input logic signed [31:0] sp, pv, input logic [2:0] md,
			output drive_t r);
		longint      e, t, inc, diff, a, c, n, y;
		logic [63:0] ti_eff;
		logic [2:0]  kind;
		logic        run_m, casc_m, hold_m, do_p, do_i, do_back, do_d, lim;
		if (md >= MODE_RESET) begin
			i_acc = 0;
			d_acc = 0;
			p_acc = 0;
			e_prev = 0;
			pv_prev = 0;
			y_prev = 0;
			r.drive = '0;
			r.clamped = 1'b0;
			return;
		end
		kind = structure[2:0];
		run_m = md == MODE_AUTO;
		casc_m = md == MODE_CASCADE;
		hold_m = md == MODE_HALT || md == MODE_MANUAL;
		{do_p, do_i, do_back, do_d} = '0;
		e = clip32(longint'(sp) - longint'(pv));
		case (kind)
			STRUCT_P: do_p = 1'b1;
			STRUCT_PI: begin
				if (run_m) {do_p, do_i} = 2'b11;
				else if (hold_m) {do_p, do_back} = 2'b11;
			end
			STRUCT_PD: begin
				if (run_m || casc_m) {do_p, do_d} = 2'b11;
			end
			STRUCT_PID: begin
				if (run_m || casc_m) {do_p, do_i, do_d} = 3'b111;
				else if (hold_m) {do_p, do_back} = 2'b11;
			end
			default: ;
		endcase
		if (do_p)
			p_acc = scale_mul(e, kp);
		if (do_i) begin
			ti_eff = (ti == 0) ? 64'd1 : ti;
			t = scale_mul(e + e_prev, kp);
			inc = div_trunc(t * longint'(SAMPLE_PERIOD), 2 * ti_eff);
			i_acc = clip32(i_acc + inc);
		end else if (do_back) begin
			i_acc = clip32(y_prev - p_acc - bias);
		end
		if (do_d) begin
			diff = structure[3] ? clip32(pv_prev - longint'(pv)) : clip32(e - e_prev);
			a = scale_mul(d_acc, tf);
			c = scale_mul(scale_mul(diff, kp), td);
			n = (a + c) * (longint'(1) << FRAC_BITS);
			d_acc = div_trunc(n, 64'(SAMPLE_PERIOD) + tf);
		end
		e_prev = e;
		pv_prev = longint'(pv);
		lim = 1'b0;
		y = clip32(p_acc + i_acc + d_acc + bias);
		if (y < out_lo) begin
			y = out_lo;
			lim = 1'b1;
		end else if (y > out_hi) begin
			y = out_hi;
			lim = 1'b1;
		end
		y_prev = y;
		r.drive = y[31:0];
		r.clamped = lim;
	endtask

	task automatic note_fault(input string what);
		fault_count++;
		if (fault_count <= 10) $display("mismatch: %s", what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			structure = {1'b0, STRUCT_PID};
			kp = 64'd65536;
			ti = 64'd65536;
			td = 0;
			tf = 0;
			out_hi = 983040;
			out_lo = -983040;
			bias = 0;
			i_acc = 0;
			d_acc = 0;
			p_acc = 0;
			e_prev = 0;
			pv_prev = 0;
			y_prev = 0;
			drive_due.delete();
			fault_count = 0;
			results_owed = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_STRUCTURE: structure = cfg_data[3:0];
					REG_GAIN:      kp = 64'(cfg_data[30:0]);
					REG_TI:        ti = 64'(cfg_data[30:0]);
					REG_TD:        td = 64'(cfg_data[30:0]);
					REG_TF:        tf = 64'(cfg_data[30:0]);
					REG_OUT_MAX:   out_hi = longint'(signed'(cfg_data));
					REG_OUT_MIN:   out_lo = longint'(signed'(cfg_data));
					REG_FF:        bias = longint'(signed'(cfg_data));
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got.drive = drive_output;
				got.clamped = clamped;
				if (drive_due.size() == 0) begin
					note_fault($sformatf("drive %0d clamped %0b with no request waiting",
						got.drive, got.clamped));
				end else begin
					want = drive_due.pop_front();
					if (want.drive !== got.drive || want.clamped !== got.clamped)
						note_fault($sformatf("drive exp %0d got %0d, clamped exp %0b got %0b",
							want.drive, got.drive, want.clamped, got.clamped));
				end
			end
			if (in_valid && !in_stall) begin
				predict_drive(setpoint, process_value, mode, want);
				drive_due.push_back(want);
			end
			results_owed = drive_due.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
// testbench top: drives requests and register writes into the pid controller and gives the verdict
module tb;
	import pcm_pkg::*;

	localparam int SAMPLE_PERIOD = 65536;
	localparam int FRAC_BITS     = 16;
	localparam int ONE           = 1 << FRAC_BITS;
	// codes above reset act as reset
	localparam logic [2:0] MODE_TOP     = 3'd7;
	// structure code with no controller behind it
	localparam logic [2:0] STRUCT_SPARE = 3'd6;

	logic               clk, arst_n;
	logic               in_valid, in_stall, out_valid, out_stall, clamped;
	logic signed [31:0] setpoint, process_value, drive_output;
	logic [2:0]         mode, cfg_index;
	logic               cfg_write;
	logic [31:0]        cfg_data;
	int                 fault_count, results_owed, items_sent;
	logic               tx_idle, rx_idle;

	pid_controller_modes_top #(.SAMPLE_PERIOD(SAMPLE_PERIOD), .FRAC_BITS(FRAC_BITS)) uut (.*);
	pid_drive_checker #(.SAMPLE_PERIOD(SAMPLE_PERIOD), .FRAC_BITS(FRAC_BITS)) chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#15000000;
		$display("FAIL");
		$finish;
	end

	initial begin : drain
		int hold;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			hold = rx_idle ? $urandom_range(0, 6) : 0;
			if (hold > 0) begin
				@(negedge clk) out_stall <= 1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk) out_stall <= 0;
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 11))
			0: return S32_MAX;
			1: return S32_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_time(input int unsigned lo, hi);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 31'($urandom);
			default: return 31'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic send_sample(input logic signed [31:0] sp, pv, input logic [2:0] md);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			@(negedge clk) in_valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1;
		setpoint <= sp;
		process_value <= pv;
		mode <= md;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic load_cfg(input logic [3:0] s, input logic [30:0] k, t_i, t_d, t_f,
			input logic signed [31:0] hi, lo, ff);
		@(negedge clk) in_valid <= 0;
		while (results_owed != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		write_reg(REG_STRUCTURE, 32'(s));
		write_reg(REG_GAIN, 32'(k));
		write_reg(REG_TI, 32'(t_i));
		write_reg(REG_TD, 32'(t_d));
		write_reg(REG_TF, 32'(t_f));
		write_reg(REG_OUT_MAX, hi);
		write_reg(REG_OUT_MIN, lo);
		write_reg(REG_FF, ff);
		@(negedge clk) cfg_write <= 0;
	endtask

	initial begin : stim
		logic [3:0]         s;
		logic               dpv;
		logic signed [31:0] hi, lo, ff, sp, pv;
		logic [2:0]         md, seg_mode;
		int                 goal, pv_track, n;
		arst_n = 0;
		in_valid = 0;
		setpoint = 0;
		process_value = 0;
		mode = MODE_AUTO;
		cfg_write = 0;
		cfg_index = REG_STRUCTURE;
		cfg_data = 0;
		items_sent = 0;
		tx_idle = 1;
		rx_idle = 1;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1;

		// defaults after reset
		send_sample(0, 0, MODE_AUTO);
		send_sample(S32_MAX, S32_MIN, MODE_AUTO);
		send_sample(S32_MIN, S32_MAX, MODE_AUTO);
		send_sample(2 * ONE, ONE, MODE_CASCADE);
		send_sample(ONE, 0, MODE_HALT);
		send_sample(ONE, 0, MODE_MANUAL);
		send_sample(3 * ONE, ONE, MODE_RESET);
		send_sample(ONE, 0, MODE_TOP);

		// derivative on measurement, zero integral time
		load_cfg({1'b1, STRUCT_PID}, 31'(2 * ONE), 31'(0), 31'(2 * ONE), 31'(ONE / 2),
			15 * ONE, -15 * ONE, ONE);
		send_sample(ONE, ONE / 2, MODE_AUTO);
		send_sample(ONE, -ONE / 2, MODE_AUTO);
		send_sample(ONE, ONE / 4, MODE_CASCADE);
		send_sample(ONE, 0, MODE_MANUAL);

		// limits swapped
		load_cfg({1'b0, STRUCT_PI}, 31'(ONE), 31'(ONE), 31'(0), 31'(0), -ONE, ONE, 0);
		send_sample(ONE / 2, 0, MODE_AUTO);
		send_sample(-3 * ONE, 0, MODE_AUTO);
		send_sample(0, 0, MODE_CASCADE);
		send_sample(0, 0, MODE_HALT);

		load_cfg({1'b0, STRUCT_PD}, '1, '1, '1, '1, S32_MAX, S32_MIN, S32_MAX);
		send_sample(S32_MAX, S32_MIN, MODE_AUTO);
		send_sample(S32_MIN, S32_MAX, MODE_CASCADE);
		send_sample(0, 0, MODE_MANUAL);

		load_cfg({1'b1, STRUCT_I}, 31'(ONE), 31'(ONE), 31'(ONE), 31'(ONE),
			15 * ONE, -15 * ONE, 0);
		send_sample(ONE, 0, MODE_AUTO);

		load_cfg({1'b0, STRUCT_SPARE}, 31'(ONE), 31'(ONE), 31'(ONE), 31'(ONE),
			15 * ONE, -15 * ONE, ONE);
		send_sample(ONE, 0, MODE_AUTO);

		load_cfg({1'b0, STRUCT_P}, 31'(0), 31'(ONE), 31'(0), 31'(0), 15 * ONE, -15 * ONE, -ONE);
		send_sample(ONE, 0, MODE_AUTO);
		send_sample(ONE, 0, MODE_MANUAL);
		send_sample(ONE, 0, MODE_RESET);

		while (items_sent < 1650) begin
			dpv = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 4))
				0: s = 4'($urandom_range(0, 15));
				1: s = {dpv, STRUCT_P};
				2: s = {dpv, STRUCT_PI};
				3: s = {dpv, STRUCT_PD};
				default: s = {dpv, STRUCT_PID};
			endcase
			case ($urandom_range(0, 5))
				0: begin
					hi = S32_MAX;
					lo = S32_MIN;
				end
				1: begin
					lo = $urandom_range(0, 20 << 16);
					hi = lo - $urandom_range(1, 20 << 16);
				end
				2: begin
					hi = $urandom;
					lo = $urandom;
				end
				default: begin
					hi = $urandom_range(1, 100) << 16;
					lo = -($urandom_range(1, 100) << 16);
				end
			endcase
			case ($urandom_range(0, 7))
				0: ff = S32_MAX;
				1: ff = S32_MIN;
				2: ff = $urandom;
				3, 4, 5: ff = $urandom_range(0, 4 << 16) - (2 << 16);
				default: ff = 0;
			endcase
			load_cfg(s, pick_time(1 << 12, 8 << 16), pick_time(1 << 14, 20 << 16),
				pick_time(0, 4 << 16), pick_time(0, 4 << 16), hi, lo, ff);
			{tx_idle, rx_idle} = 2'($urandom_range(0, 3));
			goal = 0;
			pv_track = 0;
			seg_mode = MODE_AUTO;
			n = $urandom_range(30, 70);
			repeat (n) begin
				if ($urandom_range(0, 11) == 0) begin
					case ($urandom_range(0, 9))
						5: seg_mode = MODE_CASCADE;
						6: seg_mode = MODE_HALT;
						7: seg_mode = MODE_MANUAL;
						8: seg_mode = MODE_RESET;
						9: seg_mode = 3'($urandom_range(MODE_RESET, MODE_TOP));
						default: seg_mode = MODE_AUTO;
					endcase
				end
				if ($urandom_range(0, 9) == 0)
					goal = int'($urandom_range(0, 100 << 16)) - (50 << 16);
				if ($urandom_range(0, 9) == 0) begin
					sp = any_word();
					pv = any_word();
				end else begin
					pv_track = pv_track + (goal - pv_track) / 8
						+ int'($urandom_range(0, 2 << 16)) - (1 << 16);
					sp = goal;
					pv = pv_track;
				end
				md = ($urandom_range(0, 39) == 0) ? 3'($urandom_range(MODE_RESET, MODE_TOP))
					: seg_mode;
				send_sample(sp, pv, md);
			end
		end

		@(negedge clk) in_valid <= 0;
		while (results_owed != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fault_count == 0 && results_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
